@@ hw/rtl/ltjm_pkg.sv @@
`timescale 1ns / 1ps
package ltjm_pkg;

  typedef enum logic [1:0] {
    CMD_RX    = 2'd0,
    CMD_TX    = 2'd1,
    CMD_QUERY = 2'd2,
    CMD_SNAP  = 2'd3
  } cmd_t;

  localparam logic [15:0] GAP_MAX       = 16'hFFFF;
  localparam logic [31:0] RATE_SAT      = 32'hFFFF_FFFF;
  localparam logic [63:0] RATE_LIMIT    = 64'hFFFF_FFFF_FFFF_FFFF / 64'd250;
  localparam logic [23:0] JITTER_MAX    = 24'hFF_FFFF;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;
  localparam int          JITTER_W      = 24;

endpackage

@@ hw/rtl/ltjm_if.sv @@
`timescale 1ns / 1ps
interface ltjm_event_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] byte_count;
  logic [31:0] timestamp_ms;
  logic [15:0] interval_ms;

  modport source (output valid, command, byte_count, timestamp_ms, interval_ms, input ready);
  modport sink (input valid, command, byte_count, timestamp_ms, interval_ms, output ready);
endinterface

interface ltjm_report_if;
  logic        valid;
  logic        ready;
  logic [31:0] rx_rate_kbps;
  logic [31:0] tx_rate_kbps;
  logic [23:0] jitter_ms;
  logic        link_active;

  modport source (output valid, rx_rate_kbps, tx_rate_kbps, jitter_ms, link_active,
                  input ready);
  modport sink (input valid, rx_rate_kbps, tx_rate_kbps, jitter_ms, link_active,
                output ready);
endinterface

@@ hw/rtl/link_traffic_jitter_monitor.sv @@
`timescale 1ns / 1ps
// transmit and snapshot words are handled in the idle state; receive words pass the read,
// square and update states; a query passes the difference, numerator and start states, then
// 32-step rate divides run beside the square root, then the gap count divide
// one word at a time; a finished report waits in the output register while the next is taken
// synchronous active-high reset clears totals, baselines, gap sums and times to zero
// and the timeout to 1000 ms; the gap window memory is not cleared
module link_traffic_jitter_monitor
  import ltjm_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               activity_timeout_we,
  input  logic [31:0]        activity_timeout_wdata,
  ltjm_event_if.sink         events,
  ltjm_report_if.source      reports
);

  localparam int CW    = $clog2(WINDOW_DEPTH + 1);
  localparam int PW    = $clog2(WINDOW_DEPTH);
  localparam int SUM_W = 16 + CW;
  localparam int SQ_W  = 32 + CW;
  localparam int DW    = 2 * CW + 32;
  localparam int RW    = DW + 16;
  localparam int SW    = RW / 2;

  typedef enum logic [3:0] {
    S_IDLE, S_RX_RD, S_RX_SQ, S_RX_UPD, S_Q_DIFF, S_Q_NUM, S_Q_START,
    S_Q_RUN, S_Q_JSTART, S_Q_JDIV, S_Q_OUT
  } state_t;

  state_t state;

  logic [31:0]      timeout;
  logic [CW-1:0]    gap_count;
  logic [PW-1:0]    wp;
  logic [SUM_W-1:0] gap_sum;
  logic [SQ_W-1:0]  gap_sq;
  logic [63:0]      rx_total, tx_total, rx_base, tx_base;
  logic [31:0]      last_rx, last_tx;

  logic [15:0]      gap_mem [WINDOW_DEPTH];
  logic [15:0]      rd_data;

  logic [15:0]      bytes;
  logic [31:0]      now;
  logic [15:0]      interval;
  logic [15:0]      gap, old_gap;
  logic [31:0]      sq_new, sq_old;

  logic [63:0]      rx_diff, tx_diff;
  logic [71:0]      rx_num, tx_num;
  logic             rx_big, tx_big;
  logic [DW-1:0]    prod_nsq, prod_ss, d_val;
  logic             active, jit_zero;
  logic             rx_div, tx_div;
  logic [31:0]      rx_rate, tx_rate;
  logic [23:0]      jitter;

  logic             out_valid;
  logic [31:0]      out_rx, out_tx;
  logic [23:0]      out_jit;
  logic             out_act;

  logic             accept, full;
  logic [31:0]      rx_age_now;
  logic             rx_start, tx_start, sq_start, j_start;
  logic             rx_busy, tx_busy, sq_busy, j_busy;
  logic [31:0]      rx_quo, tx_quo;
  logic [SW-1:0]    root, j_quo;

  assign events.ready = (state == S_IDLE);
  assign accept       = events.valid && events.ready;
  assign full         = (gap_count == CW'(WINDOW_DEPTH));
  assign rx_age_now   = now - last_rx;

  assign reports.valid        = out_valid;
  assign reports.rx_rate_kbps = out_rx;
  assign reports.tx_rate_kbps = out_tx;
  assign reports.jitter_ms    = out_jit;
  assign reports.link_active  = out_act;

  assign rx_start = (state == S_Q_START) && (interval != 16'd0) && !rx_big &&
                    (rx_num[71:32] < {24'd0, interval});
  assign tx_start = (state == S_Q_START) && (interval != 16'd0) && !tx_big &&
                    (tx_num[71:32] < {24'd0, interval});
  assign sq_start = (state == S_Q_START);
  assign j_start  = (state == S_Q_JSTART);

  ltjm_divider #(.NUM_W(32), .DEN_W(16)) u_rx_div (
    .clk(clk), .rst(rst), .start(rx_start), .num(rx_num[31:0]),
    .rem_init(rx_num[47:32]), .den(interval), .busy(rx_busy), .quo(rx_quo)
  );

  ltjm_divider #(.NUM_W(32), .DEN_W(16)) u_tx_div (
    .clk(clk), .rst(rst), .start(tx_start), .num(tx_num[31:0]),
    .rem_init(tx_num[47:32]), .den(interval), .busy(tx_busy), .quo(tx_quo)
  );

  ltjm_isqrt #(.OP_W(RW)) u_isqrt (
    .clk(clk), .rst(rst), .start(sq_start), .op({d_val, 16'd0}),
    .busy(sq_busy), .root(root)
  );

  // largest r with (r*n)^2 <= d*2^16 is floor(isqrt(d*2^16) / n)
  ltjm_divider #(.NUM_W(SW), .DEN_W(CW)) u_jit_div (
    .clk(clk), .rst(rst), .start(j_start), .num(root), .rem_init('0),
    .den(gap_count), .busy(j_busy), .quo(j_quo)
  );

  // gap window memory, registered read
  always_ff @(posedge clk) begin
    if (state == S_RX_RD) begin
      rd_data <= gap_mem[wp];
    end
    if (state == S_RX_UPD) begin
      gap_mem[wp] <= gap;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      timeout   <= TIMEOUT_RESET;
      gap_count <= '0;
      wp        <= '0;
      gap_sum   <= '0;
      gap_sq    <= '0;
      rx_total  <= '0;
      tx_total  <= '0;
      rx_base   <= '0;
      tx_base   <= '0;
      last_rx   <= '0;
      last_tx   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (activity_timeout_we) begin
        timeout <= activity_timeout_wdata;
      end
      if (out_valid && reports.ready && (state != S_Q_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            bytes    <= events.byte_count;
            now      <= events.timestamp_ms;
            interval <= events.interval_ms;
            unique case (cmd_t'(events.command))
              CMD_RX:    state <= S_RX_RD;
              CMD_TX: begin
                tx_total <= tx_total + {48'd0, events.byte_count};
                last_tx  <= events.timestamp_ms;
              end
              CMD_SNAP: begin
                rx_base <= rx_total;
                tx_base <= tx_total;
              end
              CMD_QUERY: state <= S_Q_DIFF;
            endcase
          end
        end
        S_RX_RD: begin
          gap   <= (|rx_age_now[31:16]) ? GAP_MAX : rx_age_now[15:0];
          state <= S_RX_SQ;
        end
        S_RX_SQ: begin
          // oldest gap leaves the sums only once the window is full
          old_gap <= full ? rd_data : 16'd0;
          sq_old  <= full ? rd_data * rd_data : 32'd0;
          sq_new  <= gap * gap;
          state   <= S_RX_UPD;
        end
        S_RX_UPD: begin
          gap_sum  <= gap_sum - SUM_W'(old_gap) + SUM_W'(gap);
          gap_sq   <= gap_sq - SQ_W'(sq_old) + SQ_W'(sq_new);
          if (!full) begin
            gap_count <= gap_count + 1'b1;
          end
          wp       <= (wp == PW'(WINDOW_DEPTH - 1)) ? '0 : wp + 1'b1;
          rx_total <= rx_total + {48'd0, bytes};
          last_rx  <= now;
          state    <= S_IDLE;
        end
        S_Q_DIFF: begin
          rx_diff  <= rx_total - rx_base;
          tx_diff  <= tx_total - tx_base;
          prod_nsq <= gap_count * gap_sq;
          prod_ss  <= gap_sum * gap_sum;
          active   <= (rx_age_now < timeout) || ((now - last_tx) < timeout);
          jit_zero <= (gap_count < CW'(2));
          state    <= S_Q_NUM;
        end
        S_Q_NUM: begin
          // times 250 as 256 - 4 - 2
          rx_num <= ({8'd0, rx_diff} << 8) - ({8'd0, rx_diff} << 2) - ({8'd0, rx_diff} << 1);
          tx_num <= ({8'd0, tx_diff} << 8) - ({8'd0, tx_diff} << 2) - ({8'd0, tx_diff} << 1);
          rx_big <= (rx_diff > RATE_LIMIT);
          tx_big <= (tx_diff > RATE_LIMIT);
          d_val  <= prod_nsq - prod_ss;
          state  <= S_Q_START;
        end
        S_Q_START: begin
          rx_div  <= rx_start;
          tx_div  <= tx_start;
          rx_rate <= (interval == 16'd0) ? 32'd0 : RATE_SAT;
          tx_rate <= (interval == 16'd0) ? 32'd0 : RATE_SAT;
          state   <= S_Q_RUN;
        end
        S_Q_RUN: begin
          if (!rx_busy && !tx_busy && !sq_busy) begin
            if (rx_div) begin
              rx_rate <= rx_quo;
            end
            if (tx_div) begin
              tx_rate <= tx_quo;
            end
            state <= S_Q_JSTART;
          end
        end
        S_Q_JSTART: state <= S_Q_JDIV;
        S_Q_JDIV: begin
          if (!j_busy) begin
            if (jit_zero) begin
              jitter <= 24'd0;
            end else if (|j_quo[SW-1:JITTER_W]) begin
              jitter <= JITTER_MAX;
            end else begin
              jitter <= j_quo[JITTER_W-1:0];
            end
            state <= S_Q_OUT;
          end
        end
        S_Q_OUT: begin
          if (!out_valid || reports.ready) begin
            out_valid <= 1'b1;
            out_rx    <= rx_rate;
            out_tx    <= tx_rate;
            out_jit   <= jitter;
            out_act   <= active;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    gap_count <= CW'(WINDOW_DEPTH))
    else $error("gap count above window depth");

  a_pointer_bound: assert property (@(posedge clk) disable iff (rst)
    wp <= PW'(WINDOW_DEPTH - 1))
    else $error("gap write pointer out of range");

  a_no_report_from_event: assert property (@(posedge clk) disable iff (rst)
    accept && (events.command != CMD_QUERY) |=> !$rose(out_valid))
    else $error("report raised by a non-query word");

  a_units_idle_at_report: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_OUT) |-> !rx_busy && !tx_busy && !sq_busy && !j_busy)
    else $error("report while an arithmetic unit is busy");
`endif

endmodule

@@ hw/rtl/ltjm_divider.sv @@
`timescale 1ns / 1ps
module ltjm_divider #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] rem_init,
  input  logic [DEN_W-1:0] den,
  output logic             busy,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;

  // rem_init must be below den so the quotient fits NUM_W bits
  assign trial = {rem, quo[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      cnt   <= CNT_W'(NUM_W);
      rem   <= rem_init;
      den_q <= den;
      quo   <= num;
    end else if (busy) begin
      if (trial >= {1'b0, den_q}) begin
        rem <= DEN_W'(trial - {1'b0, den_q});
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial[DEN_W-1:0];
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/ltjm_isqrt.sv @@
`timescale 1ns / 1ps
module ltjm_isqrt #(
  parameter int OP_W = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OP_W-1:0]     op,
  output logic                busy,
  output logic [OP_W/2-1:0]   root
);

  localparam int RT_W  = OP_W / 2;
  localparam int CNT_W = $clog2(RT_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [OP_W-1:0]  opr;
  logic [RT_W+1:0]  rem;
  logic [RT_W+3:0]  shifted;
  logic [RT_W+3:0]  trial;

  // one result bit per step from the next two operand bits
  assign shifted = {rem, opr[OP_W-1:OP_W-2]};
  assign trial   = {2'b00, root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(RT_W);
      opr  <= op;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      if (shifted >= trial) begin
        rem  <= (RT_W + 2)'(shifted - trial);
        root <= {root[RT_W-2:0], 1'b1};
      end else begin
        rem  <= shifted[RT_W+1:0];
        root <= {root[RT_W-2:0], 1'b0};
      end
      opr <= {opr[OP_W-3:0], 2'b00};
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule
